// ===== rtl/cka_pkg.sv =====
// Shared types, constants and register codes for the color-key alpha matte.
`timescale 1ns / 1ps

package cka_pkg;

  // Field and datapath widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CD_W      = 10;
  localparam int SQ_W      = 16;  // one squared channel difference
  localparam int K_W       = 18;  // sum of three squares
  localparam int N_W       = 26;  // 255 * k
  localparam int D2_W      = 20;  // color_difference squared
  localparam int CMP_W     = 28;  // divisor shifted left by up to eight
  localparam int DIV_STEPS = 8;   // quotient bits before saturation

  // Constants of the alpha math
  localparam logic [PIX_W-1:0] ALPHA_MAX     = 8'd255;
  localparam logic [PIX_W-1:0] ALPHA_MID     = 8'd127;
  localparam logic [PIX_W-1:0] CONTRAST_BASE = 8'd128;

  // Reset values of the configuration registers
  localparam logic [PIX_W-1:0] KEY_RESET  = 8'd0;
  localparam logic [CD_W-1:0]  CD_RESET   = 10'd32;
  localparam logic [PIX_W-1:0] SMTH_RESET = 8'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_RED    = 3'd0,
    REG_KEY_GREEN  = 3'd1,
    REG_KEY_BLUE   = 3'd2,
    REG_COLOR_DIFF = 3'd3,
    REG_SMOOTHNESS = 3'd4
  } cfg_reg_t;

  // Input pixel item
  typedef struct packed {
    logic [PIX_W-1:0] in_alpha;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } in_pix_t;

  // Result pixel item
  typedef struct packed {
    logic [PIX_W-1:0] out_alpha;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
  } out_pix_t;

  // Item state inside the divider stages
  typedef struct packed {
    in_pix_t          pix;
    logic [N_W-1:0]   rem;
    logic [PIX_W-1:0] quo;
    logic             sat;
  } div_t;

endpackage

// ===== rtl/cka_front.sv =====
// Front stages: channel distances, squared distance sum, saturation check.
`timescale 1ns / 1ps

module cka_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cka_pkg::in_pix_t           in_data,
  input  logic [cka_pkg::PIX_W-1:0]  key_red,
  input  logic [cka_pkg::PIX_W-1:0]  key_green,
  input  logic [cka_pkg::PIX_W-1:0]  key_blue,
  input  logic [cka_pkg::D2_W-1:0]   d2,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cka_pkg::div_t              out_data
);

  logic [cka_pkg::PIX_W-1:0] dr;
  logic [cka_pkg::PIX_W-1:0] dg;
  logic [cka_pkg::PIX_W-1:0] db;

  logic                     s1_valid_r;
  logic                     s1_ready;
  cka_pkg::in_pix_t         s1_pix_r;
  logic [cka_pkg::SQ_W-1:0] s1_sqr_r;
  logic [cka_pkg::SQ_W-1:0] s1_sqg_r;
  logic [cka_pkg::SQ_W-1:0] s1_sqb_r;
  logic [cka_pkg::SQ_W-1:0] s1_sqr_nxt;
  logic [cka_pkg::SQ_W-1:0] s1_sqg_nxt;
  logic [cka_pkg::SQ_W-1:0] s1_sqb_nxt;

  logic                     s2_valid_r;
  logic                     s2_ready;
  cka_pkg::in_pix_t         s2_pix_r;
  logic [cka_pkg::K_W-1:0]  k_sum;
  logic [cka_pkg::N_W-1:0]  s2_n_r;
  logic [cka_pkg::N_W-1:0]  s2_n_nxt;

  logic                     s3_valid_r;
  logic                     s3_ready;
  cka_pkg::div_t            s3_data_r;
  cka_pkg::div_t            s3_data_nxt;
  logic [cka_pkg::CMP_W-1:0] sat_lim;

  // Ready chain: a stage loads when empty or when its item moves on
  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: absolute channel differences, squared
  always_comb begin
    dr = (key_red > in_data.in_red) ? (key_red - in_data.in_red)
                                    : (in_data.in_red - key_red);
    dg = (key_green > in_data.in_green) ? (key_green - in_data.in_green)
                                        : (in_data.in_green - key_green);
    db = (key_blue > in_data.in_blue) ? (key_blue - in_data.in_blue)
                                      : (in_data.in_blue - key_blue);
    s1_sqr_nxt = {8'd0, dr} * {8'd0, dr};
    s1_sqg_nxt = {8'd0, dg} * {8'd0, dg};
    s1_sqb_nxt = {8'd0, db} * {8'd0, db};
  end

  // Stage 2: sum of squares, then times 255 as (k << 8) - k
  always_comb begin
    k_sum    = cka_pkg::K_W'(s1_sqr_r) + cka_pkg::K_W'(s1_sqg_r)
             + cka_pkg::K_W'(s1_sqb_r);
    s2_n_nxt = {k_sum, 8'd0} - cka_pkg::N_W'(k_sum);
  end

  // Stage 3: quotient saturates when n >= 256 * d2 (always when d2 is zero)
  always_comb begin
    sat_lim         = {d2, 8'd0};
    s3_data_nxt.pix = s2_pix_r;
    s3_data_nxt.rem = s2_n_r;
    s3_data_nxt.sat = ({2'd0, s2_n_r} >= sat_lim);
    s3_data_nxt.quo = s3_data_nxt.sat ? cka_pkg::ALPHA_MAX : '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  // Payload registers: load with the stage, hold otherwise
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_pix_r <= in_data;
      s1_sqr_r <= s1_sqr_nxt;
      s1_sqg_r <= s1_sqg_nxt;
      s1_sqb_r <= s1_sqb_nxt;
    end
    if (s2_ready) begin
      s2_pix_r <= s1_pix_r;
      s2_n_r   <= s2_n_nxt;
    end
    if (s3_ready) begin
      s3_data_r <= s3_data_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_data_r;

endmodule

// ===== rtl/cka_div_step.sv =====
// One restoring division step: resolves a single quotient bit per stage.
`timescale 1ns / 1ps

module cka_div_step #(
  parameter int STEP_BIT = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cka_pkg::div_t             in_data,
  input  logic [cka_pkg::D2_W-1:0]  d2,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cka_pkg::div_t             out_data
);

  logic                      valid_r;
  cka_pkg::div_t             data_r;
  cka_pkg::div_t             data_nxt;
  logic [cka_pkg::CMP_W-1:0] rem_ext;
  logic [cka_pkg::CMP_W-1:0] dsh;
  logic [cka_pkg::CMP_W-1:0] diff;

  assign in_ready = !valid_r || out_ready;

  // Subtract the shifted divisor when it fits; a saturated item passes as is
  always_comb begin
    rem_ext  = cka_pkg::CMP_W'(in_data.rem);
    dsh      = cka_pkg::CMP_W'(d2) << STEP_BIT;
    diff     = rem_ext - dsh;
    data_nxt = in_data;
    if (!in_data.sat && (rem_ext >= dsh)) begin
      data_nxt.rem           = cka_pkg::N_W'(diff);
      data_nxt.quo[STEP_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/cka_finish.sv =====
// Final stage: contrast push on the keyed alpha, scale by input alpha.
`timescale 1ns / 1ps

module cka_finish (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cka_pkg::div_t              in_data,
  input  logic [cka_pkg::PIX_W-1:0]  smoothness,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cka_pkg::out_pix_t          out_data
);

  logic                       valid_r;
  cka_pkg::out_pix_t          data_r;
  cka_pkg::out_pix_t          data_nxt;
  logic [cka_pkg::PIX_W-1:0]  contrast;
  logic [cka_pkg::PIX_W-1:0]  alpha;
  logic [cka_pkg::PIX_W:0]    raised;
  logic [2*cka_pkg::PIX_W-1:0] prod;

  assign in_ready = !valid_r || out_ready;

  // Contrast is 128 - smoothness, applied only when positive
  always_comb begin
    contrast = cka_pkg::CONTRAST_BASE - smoothness;
    alpha    = in_data.quo;
    raised   = {1'b0, in_data.quo} + {1'b0, contrast};
    if (smoothness < cka_pkg::CONTRAST_BASE) begin
      if (in_data.quo < cka_pkg::ALPHA_MID) begin
        alpha = (in_data.quo > contrast) ? (in_data.quo - contrast) : '0;
      end else begin
        alpha = (raised < {1'b0, cka_pkg::ALPHA_MAX}) ? raised[cka_pkg::PIX_W-1:0]
                                                      : cka_pkg::ALPHA_MAX;
      end
    end
    prod               = {8'd0, alpha} * {8'd0, in_data.pix.in_alpha};
    data_nxt.out_alpha = prod[2*cka_pkg::PIX_W-1:cka_pkg::PIX_W];
    data_nxt.out_red   = in_data.pix.in_red;
    data_nxt.out_green = in_data.pix.in_green;
    data_nxt.out_blue  = in_data.pix.in_blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/color_key_alpha_matte_core.sv =====
// Top level of the color-key alpha matte: config registers and the pixel pipeline.
//
//   channel | ports                              | direction | carries
//   --------+------------------------------------+-----------+---------------------------
//   input   | in_valid, in_ready, in_data        | in        | one ARGB pixel item
//   result  | out_valid, out_ready, out_data     | out       | keyed ARGB pixel item
//   config  | cfg_we, cfg_index, cfg_data        | in        | register write, no wait
//
// One item per clock while out_ready holds; an accepted item passes to out_valid through
// three front stages, eight stages of the bit-per-stage divider and one finish stage.
// The divider chain makes up most of the stages; every stage holds its own valid bit.
// A stalled output back-fills empty stages before in_ready drops; nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and restores register defaults.
`timescale 1ns / 1ps

module color_key_alpha_matte_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cka_pkg::in_pix_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cka_pkg::out_pix_t             out_data,
  input  logic                          cfg_we,
  input  logic [cka_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cka_pkg::CFG_W-1:0]     cfg_data
);

  logic [cka_pkg::PIX_W-1:0] key_red_r;
  logic [cka_pkg::PIX_W-1:0] key_green_r;
  logic [cka_pkg::PIX_W-1:0] key_blue_r;
  logic [cka_pkg::CD_W-1:0]  color_diff_r;
  logic [cka_pkg::PIX_W-1:0] smoothness_r;
  logic [cka_pkg::D2_W-1:0]  d2_r;
  logic [cka_pkg::D2_W-1:0]  d2_nxt;

  logic          stg_valid [0:cka_pkg::DIV_STEPS];
  logic          stg_ready [0:cka_pkg::DIV_STEPS];
  cka_pkg::div_t stg_data  [0:cka_pkg::DIV_STEPS];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r    <= cka_pkg::KEY_RESET;
      key_green_r  <= cka_pkg::KEY_RESET;
      key_blue_r   <= cka_pkg::KEY_RESET;
      color_diff_r <= cka_pkg::CD_RESET;
      smoothness_r <= cka_pkg::SMTH_RESET;
    end else if (cfg_we) begin
      unique case (cka_pkg::cfg_reg_t'(cfg_index))
        cka_pkg::REG_KEY_RED:    key_red_r    <= cfg_data[cka_pkg::PIX_W-1:0];
        cka_pkg::REG_KEY_GREEN:  key_green_r  <= cfg_data[cka_pkg::PIX_W-1:0];
        cka_pkg::REG_KEY_BLUE:   key_blue_r   <= cfg_data[cka_pkg::PIX_W-1:0];
        cka_pkg::REG_COLOR_DIFF: color_diff_r <= cfg_data[cka_pkg::CD_W-1:0];
        cka_pkg::REG_SMOOTHNESS: smoothness_r <= cfg_data[cka_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Divisor: color_difference squared, ready before any item reaches stage 3
  assign d2_nxt = {10'd0, color_diff_r} * {10'd0, color_diff_r};

  always_ff @(posedge clk) begin
    d2_r <= d2_nxt;
  end

  cka_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .key_red   (key_red_r),
    .key_green (key_green_r),
    .key_blue  (key_blue_r),
    .d2        (d2_r),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar g = 0; g < cka_pkg::DIV_STEPS; g++) begin : g_div
    cka_div_step #(
      .STEP_BIT (cka_pkg::DIV_STEPS - 1 - g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .d2        (d2_r),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  cka_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[cka_pkg::DIV_STEPS]),
    .in_ready   (stg_ready[cka_pkg::DIV_STEPS]),
    .in_data    (stg_data[cka_pkg::DIV_STEPS]),
    .smoothness (smoothness_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== bench/cka_matte_checker.sv =====
// Checker for the color-key alpha matte: predicts each keyed pixel and compares results.
`timescale 1ns / 1ps

module cka_matte_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  cka_pkg::in_pix_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  cka_pkg::out_pix_t             out_data,
  input  logic                          cfg_we,
  input  logic [cka_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cka_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   pixels_pending,
  output int unsigned                   pixels_checked
);
  import cka_pkg::*;

  localparam int PRINT_CAP = 40;

  // Shadow copy of the register file
  logic [PIX_W-1:0] key_red;
  logic [PIX_W-1:0] key_green;
  logic [PIX_W-1:0] key_blue;
  logic [CD_W-1:0]  radius;
  logic [PIX_W-1:0] smooth;

  out_pix_t expected_pixels[$];

  initial begin
    mismatches     = 0;
    pixels_pending = 0;
    pixels_checked = 0;
  end

  function automatic int chan_dist_sq(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // Keyed alpha from the squared RGB distance, then the contrast push and the scale by input alpha
  function automatic out_pix_t matte_pixel(input in_pix_t pix);
    int sq_sum;
    int span;
    int keyed;
    int contrast;
    out_pix_t res;
    sq_sum = chan_dist_sq(key_red, pix.in_red) + chan_dist_sq(key_green, pix.in_green)
           + chan_dist_sq(key_blue, pix.in_blue);
    keyed = int'(ALPHA_MAX);
    // zero radius keeps the keyed alpha at full
    if (radius != '0) begin
      span  = int'(radius) * int'(radius);
      keyed = (int'(ALPHA_MAX) * sq_sum) / span;
      if (keyed > int'(ALPHA_MAX)) keyed = int'(ALPHA_MAX);
    end
    contrast = int'(CONTRAST_BASE) - int'(smooth);
    if (contrast > 0) begin
      if (keyed < int'(ALPHA_MID)) begin
        keyed = (keyed > contrast) ? keyed - contrast : 0;
      end else begin
        keyed = (keyed + contrast < int'(ALPHA_MAX)) ? keyed + contrast : int'(ALPHA_MAX);
      end
    end
    res.out_alpha = PIX_W'((keyed * int'(pix.in_alpha)) >> PIX_W);
    res.out_red   = pix.in_red;
    res.out_green = pix.in_green;
    res.out_blue  = pix.in_blue;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("checker: pixel %0d: %s", pixels_checked, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    out_pix_t want;
    if (!rst_n) begin
      key_red   = KEY_RESET;
      key_green = KEY_RESET;
      key_blue  = KEY_RESET;
      radius    = CD_RESET;
      smooth    = SMTH_RESET;
      expected_pixels.delete();
    end else begin
      // compare the result item with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %h with no pixel outstanding", out_data));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.out_alpha !== want.out_alpha)
            report_mismatch($sformatf("alpha %0d, want %0d", out_data.out_alpha, want.out_alpha));
          if (out_data.out_red !== want.out_red)
            report_mismatch($sformatf("red %0d, want %0d", out_data.out_red, want.out_red));
          if (out_data.out_green !== want.out_green)
            report_mismatch($sformatf("green %0d, want %0d", out_data.out_green, want.out_green));
          if (out_data.out_blue !== want.out_blue)
            report_mismatch($sformatf("blue %0d, want %0d", out_data.out_blue, want.out_blue));
          pixels_checked++;
        end
      end
      // predict each accepted input item
      if (in_valid && in_ready) expected_pixels.push_back(matte_pixel(in_data));
      // track register writes, masked to width; other indexes drop
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_RED:    key_red   = cfg_data[PIX_W-1:0];
          REG_KEY_GREEN:  key_green = cfg_data[PIX_W-1:0];
          REG_KEY_BLUE:   key_blue  = cfg_data[PIX_W-1:0];
          REG_COLOR_DIFF: radius    = cfg_data[CD_W-1:0];
          REG_SMOOTHNESS: smooth    = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the color-key alpha matte bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import cka_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int LATENCY        = 12;
  localparam int SETTLE_CYCLES  = 3 * LATENCY;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int ROUNDS         = 8;
  localparam int ROUND_PIXELS   = 50;
  localparam int CHAN_MAX       = (1 << PIX_W) - 1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_pix_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_pix_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_RED;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int unsigned mismatches;
  int unsigned pixels_pending;
  int unsigned pixels_checked;
  int unsigned cycle_count      = 0;
  int unsigned settings_applied = 0;

  // Idling controls for the input feed and the result drain
  bit feed_gaps    = 1'b0;
  bit drain_stalls = 1'b0;
  bit squeeze_req  = 1'b0;

  // Key and radius currently programmed, used to aim pixels near the key
  logic [PIX_W-1:0] cur_key_red   = KEY_RESET;
  logic [PIX_W-1:0] cur_key_green = KEY_RESET;
  logic [PIX_W-1:0] cur_key_blue  = KEY_RESET;
  logic [CD_W-1:0]  cur_radius    = CD_RESET;

  always #HALF_PERIOD clk = ~clk;

  color_key_alpha_matte_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cka_matte_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked)
  );

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: no progress after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic in_pix_t pix(input int a, input int r, input int g, input int b);
    in_pix_t p;
    p.in_alpha = PIX_W'(a);
    p.in_red   = PIX_W'(r);
    p.in_green = PIX_W'(g);
    p.in_blue  = PIX_W'(b);
    return p;
  endfunction

  // Mostly near the key so the alpha ramp gets exercised, sometimes anywhere
  function automatic logic [PIX_W-1:0] pick_channel(input logic [PIX_W-1:0] centre,
                                                    input int spread);
    int v;
    if ($urandom_range(0, 3) == 0) return PIX_W'($urandom);
    v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > CHAN_MAX) v = CHAN_MAX;
    return PIX_W'(v);
  endfunction

  function automatic in_pix_t near_key_pixel(input int spread);
    in_pix_t p;
    int roll;
    roll = $urandom_range(0, 9);
    p.in_alpha = (roll == 0) ? '0 : (roll == 1) ? '1 : PIX_W'($urandom);
    p.in_red   = pick_channel(cur_key_red, spread);
    p.in_green = pick_channel(cur_key_green, spread);
    p.in_blue  = pick_channel(cur_key_blue, spread);
    return p;
  endfunction

  // Offer one item and hold it until accepted, then maybe idle
  task automatic feed_pixel(input in_pix_t p);
    int gap;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = feed_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every prediction has been matched
  task automatic drain_phase();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixels_pending != 0);
    @(posedge clk);
  endtask

  // Write all five registers plus one write to an unused index
  task automatic program_matte(input logic [CFG_W-1:0] kr, input logic [CFG_W-1:0] kg,
                               input logic [CFG_W-1:0] kb, input logic [CFG_W-1:0] radius,
                               input logic [CFG_W-1:0] smooth);
    logic [CFG_IDX_W-1:0] unused_idx;
    unused_idx = CFG_IDX_W'(int'(REG_SMOOTHNESS)
                 + $urandom_range(1, (1 << CFG_IDX_W) - 1 - int'(REG_SMOOTHNESS)));
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_RED;
    cfg_data  <= kr;
    @(posedge clk);
    cfg_index <= REG_KEY_GREEN;
    cfg_data  <= kg;
    @(posedge clk);
    cfg_index <= REG_KEY_BLUE;
    cfg_data  <= kb;
    @(posedge clk);
    cfg_index <= REG_COLOR_DIFF;
    cfg_data  <= radius;
    @(posedge clk);
    cfg_index <= REG_SMOOTHNESS;
    cfg_data  <= smooth;
    @(posedge clk);
    cfg_index <= unused_idx;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_key_red   = kr[PIX_W-1:0];
    cur_key_green = kg[PIX_W-1:0];
    cur_key_blue  = kb[PIX_W-1:0];
    cur_radius    = radius[CD_W-1:0];
    settings_applied++;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_drain
    int stall_left;
    stall_left = 0;
    forever begin
      if (squeeze_req) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
      end else begin
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          if (drain_stalls) stall_left = idle_gap();
        end
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] radius_pick;
    logic [CFG_W-1:0] smooth_pick;
    int spread;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: black key, radius 32, full contrast; floor and cap
    feed_pixel(pix(0, 0, 0, 0));
    feed_pixel(pix(255, 0, 0, 0));
    feed_pixel(pix(255, 255, 255, 255));
    feed_pixel(pix(255, 1, 0, 0));
    feed_pixel(pix(128, 3, 2, 1));
    drain_phase();

    // Zero radius with contrast switched off: alpha passes scaled by 255
    program_matte(200, 100, 50, 0, 255);
    feed_pixel(pix(255, 200, 100, 50));
    feed_pixel(pix(1, 0, 0, 0));
    feed_pixel(pix(0, 255, 255, 255));
    drain_phase();

    // Widest radius, contrast exactly zero
    program_matte(10, 20, 30, 1023, 128);
    feed_pixel(pix(255, 255, 255, 255));
    feed_pixel(pix(255, 10, 20, 30));
    feed_pixel(pix(77, 0, 0, 0));
    drain_phase();

    // Wide writes with masked upper bits; contrast of one around mid alpha
    program_matte(10'h300, 10'h3ff, 10'h100, 16, 10'h37f);
    feed_pixel(pix(255, 8, 247, 0));
    feed_pixel(pix(200, 11, 253, 1));
    feed_pixel(pix(255, 0, 255, 0));
    feed_pixel(pix(255, 255, 0, 255));
    drain_phase();

    // Random rounds, each under its own setting
    for (int round = 0; round < ROUNDS; round++) begin
      case ($urandom_range(0, 4))
        0:       smooth_pick = 0;
        1:       smooth_pick = 127;
        2:       smooth_pick = 128;
        3:       smooth_pick = 255;
        default: smooth_pick = CFG_W'($urandom);
      endcase
      case (round)
        0:       radius_pick = 1;
        1:       radius_pick = 1023;
        2:       radius_pick = 0;
        default: radius_pick = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1, 48))
                                                           : CFG_W'($urandom);
      endcase
      if (round == 1) smooth_pick = 255;
      program_matte(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                    radius_pick, smooth_pick);

      // Some rounds run back to back on one or both sides
      feed_gaps    = (round != 1) && (round != 4);
      drain_stalls = (round != 4) && (round != 6);
      // Hold the result side off long enough to back up into the input
      if (round == 1) squeeze_req = 1'b1;

      spread = int'(cur_radius) / 2 + 3;
      for (int n = 0; n < ROUND_PIXELS; n++) feed_pixel(near_key_pixel(spread));
      drain_phase();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("tb: %0d pixels checked under %0d register settings plus reset defaults",
             pixels_checked, settings_applied);
    $display("tb: zero and full radius, contrast on and off, one long output hold-off");
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
